### hw/rtl/mono_bitmap_column_packer_assert.svh
// assertion macros shared by the column packer modules
`ifndef MONO_BITMAP_COLUMN_PACKER_ASSERT_SVH
`define MONO_BITMAP_COLUMN_PACKER_ASSERT_SVH

`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define MBCP_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property checked at every clock edge, reset included
`define MBCP_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MBCP_ASSERT(name, clk, rst_n, prop, msg)
`define MBCP_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

### hw/rtl/mbcp_pkg.sv
// shared constants and controller/datapath interface types of the column packer
`timescale 1ns / 1ps
`default_nettype none

package mbcp_pkg;

    localparam int ROW_WORDS         = 8;
    localparam int MAX_ROWS          = 128;
    localparam int GROUPS_PER_COLUMN = 16;

    localparam int WORD_W      = 32;
    localparam int ADDR_W      = 10;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int COL_W       = 8;
    localparam int GRP_W       = 4;
    localparam int ROWSEL_W    = 3;
    localparam int BYTE_W      = 8;
    localparam int ROWCNT_W    = 8;
    localparam int COLCNT_W    = 9;
    localparam int REQ_W       = 2;
    localparam int IN_DATA_W   = 48;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // request kinds carried in tuser
    localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EMIT    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

    // register indexes (paddr[2])
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    localparam logic [ROWCNT_W-1:0] ROW_COUNT_RESET    = 8'd122;
    localparam logic [COLCNT_W-1:0] COLUMN_COUNT_RESET = 9'd250;

    typedef struct packed {
        logic                wr_en;
        logic                restart;
        logic                rd_en;
        logic [ROWSEL_W-1:0] rd_row;
        logic                load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

### hw/rtl/mono_bitmap_column_packer.sv
// top level of the 1 bpp bitmap column packer
`timescale 1ns / 1ps
`default_nettype none

// Stores a 1 bpp image (up to 1024 words of 32 pixels, row-major) and returns it as
// column-major bytes, eight vertical pixels per byte, top pixel in bit 7, rows at or
// past row_count reading as white. Write and restart transactions (tuser 0 and 2)
// are taken whenever the block is idle. An emit transaction (tuser 1) holds
// s_axis_tready low while the single read port of the image memory is used once per
// row for the eight rows of the byte, then while the registered read drains and the
// output register is loaded once it is free, so no new transaction is taken until the
// byte is loaded. The output register lets a new transaction be taken while the
// previous byte waits on m_axis_tready; m_axis_tlast marks the last byte of the
// frame. Image memory contents are undefined until written.
module mono_bitmap_column_packer (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [9:0] word_index, [41:10] word_value, [47:42] zero
    input  wire logic [mbcp_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [1:0] req_type
    input  wire logic [mbcp_pkg::REQ_W-1:0]           s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [7:0] packed_byte
    output logic [mbcp_pkg::BYTE_W-1:0]               m_axis_tdata,
    // frame_end
    output logic                                      m_axis_tlast,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [mbcp_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [mbcp_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mbcp_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                      pready
);
    import mbcp_pkg::*;

    logic [ROWCNT_W-1:0] r_row_count;
    logic [COLCNT_W-1:0] r_column_count;
    logic                w_cfg_wr;
    t_dp_cmd             w_cmd;
    t_dp_sts             w_sts;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= ROW_COUNT_RESET;
            r_column_count <= COLUMN_COUNT_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_ROW_COUNT:    r_row_count    <= pwdata[ROWCNT_W-1:0];
                REG_COLUMN_COUNT: r_column_count <= pwdata[COLCNT_W-1:0];
                default:          r_row_count    <= r_row_count;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ROW_COUNT:    prdata = APB_DATA_W'(r_row_count);
            REG_COLUMN_COUNT: prdata = APB_DATA_W'(r_column_count);
            default:          prdata = '0;
        endcase
    end

    mbcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_req_type (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    mbcp_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_word_index   (s_axis_tdata[ADDR_W-1:0]),
        .i_word_value   (s_axis_tdata[ADDR_W+WORD_W-1:ADDR_W]),
        .i_row_count    (r_row_count),
        .i_column_count (r_column_count),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_out_byte     (m_axis_tdata),
        .o_out_last     (m_axis_tlast)
    );

endmodule

`default_nettype wire

### hw/rtl/mbcp_datapath.sv
// image store, frame counters, row gather shift register and output register
`timescale 1ns / 1ps
`default_nettype none

`include "mono_bitmap_column_packer_assert.svh"

module mbcp_datapath (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire mbcp_pkg::t_dp_cmd                i_cmd,
    output mbcp_pkg::t_dp_sts                     o_sts,
    input  wire logic [mbcp_pkg::ADDR_W-1:0]      i_word_index,
    input  wire logic [mbcp_pkg::WORD_W-1:0]      i_word_value,
    input  wire logic [mbcp_pkg::ROWCNT_W-1:0]    i_row_count,
    input  wire logic [mbcp_pkg::COLCNT_W-1:0]    i_column_count,
    input  wire logic                             i_out_ready,
    output logic                                  o_out_valid,
    output logic [mbcp_pkg::BYTE_W-1:0]           o_out_byte,
    output logic                                  o_out_last
);
    import mbcp_pkg::*;

    logic [WORD_W-1:0]   r_mem [STORE_DEPTH];
    logic [WORD_W-1:0]   r_rd_data;
    logic                r_rd_pending;
    logic                r_fill_en;
    logic                r_fill_val;
    logic [BYTE_W-1:0]   r_shift;
    logic [COL_W-1:0]    r_col;
    logic [GRP_W-1:0]    r_grp;
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_last;

    logic [GRP_W+ROWSEL_W-1:0] w_y;
    logic [ADDR_W-1:0]      w_addr;
    logic                   w_beyond_max;
    logic                   w_beyond_cnt;
    logic                   w_bit;
    logic [COLCNT_W-1:0]    w_eff_cols;
    logic                   w_last_grp;
    logic                   w_last_col;

    // row of the pixel being fetched: eight rows per group
    assign w_y          = {r_grp, i_cmd.rd_row};
    assign w_addr       = ADDR_W'(int'(w_y) * ROW_WORDS + int'(r_col[COL_W-1:5]));
    assign w_beyond_max = int'(w_y) >= MAX_ROWS;
    assign w_beyond_cnt = {1'b0, w_y} >= i_row_count;

    // bit 31 is the leftmost pixel, so index is 31 - (col mod 32)
    assign w_bit = r_fill_en ? r_fill_val : r_rd_data[~r_col[4:0]];

    always_comb begin
        if (i_column_count == '0) begin
            w_eff_cols = COLCNT_W'(1);
        end else if (i_column_count > COLCNT_W'(256)) begin
            w_eff_cols = COLCNT_W'(256);
        end else begin
            w_eff_cols = i_column_count;
        end
    end

    assign w_last_grp = ({1'b0, r_grp} + (GRP_W+1)'(1)) >= (GRP_W+1)'(GROUPS_PER_COLUMN);
    assign w_last_col = ({1'b0, r_col} + COLCNT_W'(1)) >= w_eff_cols;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_word_index] <= i_word_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data  <= r_mem[w_addr];
            r_fill_en  <= w_beyond_max || w_beyond_cnt;
            r_fill_val <= !w_beyond_max;
        end
        if (r_rd_pending) begin
            r_shift <= {r_shift[BYTE_W-2:0], w_bit};
        end
        if (i_cmd.load_out) begin
            r_out_byte <= r_shift;
            r_out_last <= w_last_grp && w_last_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pending <= 1'b0;
            r_col        <= '0;
            r_grp        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_rd_pending <= i_cmd.rd_en;
            if (i_cmd.restart) begin
                r_col <= '0;
                r_grp <= '0;
            end else if (i_cmd.load_out) begin
                if (w_last_grp) begin
                    r_grp <= '0;
                    r_col <= w_last_col ? '0 : r_col + COL_W'(1);
                end else begin
                    r_grp <= r_grp + GRP_W'(1);
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_out_last     = r_out_last;

    `MBCP_ASSERT(a_frame_end_wraps, i_clk, i_rst_n,
        i_cmd.load_out && w_last_grp && w_last_col |=> r_col == '0 && r_grp == '0,
        "counters did not wrap after the frame end byte")
    `MBCP_ASSERT(a_load_sets_valid, i_clk, i_rst_n,
        i_cmd.load_out |=> r_out_valid,
        "output register not valid after a load")
    `MBCP_ASSERT(a_no_load_during_gather, i_clk, i_rst_n,
        i_cmd.load_out |-> !r_rd_pending && !i_cmd.rd_en,
        "byte loaded while rows are still being gathered")

endmodule

`default_nettype wire

### hw/rtl/mbcp_ctrl.sv
// request decode and byte gather sequencer
`timescale 1ns / 1ps
`default_nettype none

`include "mono_bitmap_column_packer_assert.svh"

module mbcp_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic [mbcp_pkg::REQ_W-1:0]    i_req_type,
    output logic                               o_in_ready,
    output mbcp_pkg::t_dp_cmd                  o_cmd,
    input  wire mbcp_pkg::t_dp_sts             i_sts
);
    import mbcp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SETTLE,
        ST_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [ROWSEL_W-1:0] r_row, n_row;
    logic                w_accept;

    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state        = r_state;
        n_row          = r_row;
        o_cmd          = '0;
        o_cmd.rd_row   = r_row;
        case (r_state)
            ST_IDLE: begin
                n_row = '0;
                if (w_accept) begin
                    case (i_req_type)
                        REQ_WRITE:   o_cmd.wr_en   = 1'b1;
                        REQ_RESTART: o_cmd.restart = 1'b1;
                        REQ_EMIT:    n_state       = ST_READ;
                        default:     n_state       = ST_IDLE;
                    endcase
                end
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_row       = r_row + ROWSEL_W'(1);
                if (r_row == '1) begin
                    n_state = ST_SETTLE;
                end
            end
            // last row's word is shifted in during this cycle
            ST_SETTLE: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
        end
    end

    `MBCP_ASSERT(a_load_when_free, i_clk, i_rst_n,
        o_cmd.load_out |-> i_sts.out_free,
        "output register overwritten before its transaction")
    `MBCP_ASSERT_ALWAYS(a_no_write_during_read, i_clk,
        !(o_cmd.rd_en && o_cmd.wr_en),
        "image write overlaps a gather read")
    `MBCP_ASSERT(a_settle_after_last_row, i_clk, i_rst_n,
        r_state == ST_SETTLE |-> $past(o_cmd.rd_en) && $past(r_row) == '1,
        "gather finished before all eight rows were read")

endmodule

`default_nettype wire

### tb/mono_bitmap_column_packer_tb.sv
// self-checking testbench for the bitmap column packer: image writes, column bytes, registers
`timescale 1ns / 1ps

module mono_bitmap_column_packer_tb;
    import mbcp_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int PHASE_COUNT = 9;
    localparam int PHASE_ITEMS = 87;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [BYTE_W-1:0] pixels;
        logic              frame_end;
    } t_column_byte;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [REQ_W-1:0]      s_axis_tuser = REQ_WRITE;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]     m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    mono_bitmap_column_packer uut (.*);

    always #5 i_clk = ~i_clk;

    // image and walk position as the block should hold them
    logic [WORD_W-1:0]   img_words [STORE_DEPTH];
    logic [COL_W-1:0]    col_pos;
    logic [GRP_W-1:0]    grp_pos;
    logic [ROWCNT_W-1:0] row_limit;
    logic [COLCNT_W-1:0] col_limit;
    t_column_byte        pending_bytes [$];
    int                  mismatch_count = 0;
    int                  src_idle_pct = 0;
    int                  sink_idle_pct = 0;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // next column byte of the walk, then step the group and column counters
    function automatic t_column_byte pack_column_byte();
        t_column_byte r;
        int           y;
        int           cols;
        logic         last_group;
        logic         last_col;
        r.pixels = '0;
        for (int b = 0; b < 8; b++) begin
            y = int'(grp_pos) * 8 + b;
            if (y >= MAX_ROWS) begin
                r.pixels[7-b] = 1'b0;
            end else if (y >= int'(row_limit)) begin
                r.pixels[7-b] = 1'b1;
            end else begin
                r.pixels[7-b] = img_words[(y * ROW_WORDS + int'(col_pos >> 5)) % STORE_DEPTH]
                                         [31 - int'(col_pos[4:0])];
            end
        end
        cols = (col_limit == 0) ? 1 : (col_limit > 256) ? 256 : int'(col_limit);
        last_group = (int'(grp_pos) + 1 >= GROUPS_PER_COLUMN);
        last_col = (int'(col_pos) + 1 >= cols);
        r.frame_end = last_group && last_col;
        if (last_group) begin
            grp_pos = '0;
            col_pos = last_col ? '0 : col_pos + 1'b1;
        end else begin
            grp_pos = grp_pos + 1'b1;
        end
        return r;
    endfunction

    function automatic void apply_request(input logic [REQ_W-1:0] req,
                                          input logic [ADDR_W-1:0] idx,
                                          input logic [WORD_W-1:0] val);
        case (req)
            REQ_WRITE: begin
                img_words[idx] = val;
            end
            REQ_EMIT: begin
                pending_bytes.push_back(pack_column_byte());
            end
            REQ_RESTART: begin
                col_pos = '0;
                grp_pos = '0;
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected byte, expected none, actual %02h frame_end %0b",
                         $time, m_axis_tdata, m_axis_tlast);
                mismatch_count++;
            end else begin
                if (m_axis_tdata !== pending_bytes[0].pixels) begin
                    $display("%0t: packed byte expected %02h, actual %02h",
                             $time, pending_bytes[0].pixels, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tlast !== pending_bytes[0].frame_end) begin
                    $display("%0t: frame_end expected %0b, actual %0b",
                             $time, pending_bytes[0].frame_end, m_axis_tlast);
                    mismatch_count++;
                end
                void'(pending_bytes.pop_front());
            end
        end
    end

    // valid stays high after a transaction so back-to-back requests need no second assignment
    task automatic send_request(input logic [REQ_W-1:0] req,
                                input logic [ADDR_W-1:0] idx,
                                input logic [WORD_W-1:0] val);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= {{(IN_DATA_W - ADDR_W - WORD_W){1'b0}}, val, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        apply_request(req, idx, val);
    endtask

    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic reg_sel,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {reg_sel, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_register(input logic reg_sel, input logic [APB_DATA_W-1:0] want);
        logic [APB_DATA_W-1:0] got;
        apb_access(1'b0, reg_sel, '0, got);
        if (got !== want) begin
            $display("%0t: register %0d expected %0d, actual %0d", $time, reg_sel, want, got);
            mismatch_count++;
        end
    endtask

    task automatic set_geometry(input int rows, input int cols);
        logic [APB_DATA_W-1:0] ignored;
        settle_block();
        apb_access(1'b1, REG_ROW_COUNT, rows, ignored);
        row_limit = rows[ROWCNT_W-1:0];
        apb_access(1'b1, REG_COLUMN_COUNT, cols, ignored);
        col_limit = cols[COLCNT_W-1:0];
        check_register(REG_ROW_COUNT, 32'(row_limit));
        check_register(REG_COLUMN_COUNT, 32'(col_limit));
    endtask

    task automatic test_register_reset();
        row_limit = ROW_COUNT_RESET;
        col_limit = COLUMN_COUNT_RESET;
        col_pos = '0;
        grp_pos = '0;
        check_register(REG_ROW_COUNT, 32'(ROW_COUNT_RESET));
        check_register(REG_COLUMN_COUNT, 32'(COLUMN_COUNT_RESET));
    endtask

    // every word is written so no byte ever reads an unwritten entry
    task automatic test_image_fill();
        logic [WORD_W-1:0] val;
        src_idle_pct = 7;
        sink_idle_pct = 69;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            if (i == 0) begin
                val = '0;
            end else if (i == STORE_DEPTH - 1) begin
                val = '1;
            end else begin
                val = $urandom;
            end
            send_request(REQ_WRITE, i[ADDR_W-1:0], val);
        end
    endtask

    // one full column at reset geometry, rows past the count come back white
    task automatic test_directed_column();
        send_request(REQ_RESTART, '0, '0);
        for (int g = 0; g < GROUPS_PER_COLUMN; g++) begin
            send_request(REQ_EMIT, '0, '0);
        end
        send_request(REQ_UNUSED, '1, '1);
        send_request(REQ_EMIT, '1, '1);
        send_request(REQ_RESTART, '1, '1);
        send_request(REQ_EMIT, '0, '0);
        settle_block();
    endtask

    task automatic test_random_traffic();
        int phase_rows [PHASE_COUNT] = '{122, 0, 128, 255, 1, 64, 200, 7, 0};
        int phase_cols [PHASE_COUNT] = '{1, 1, 2, 0, 3, 257, 511, 256, 0};
        int count;
        int pick;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p == PHASE_COUNT - 1) begin
                phase_rows[p] = $urandom_range(255);
                phase_cols[p] = $urandom_range(4, 1);
            end
            // no restart between phases, so a smaller column count can end a frame early
            set_geometry(phase_rows[p], phase_cols[p]);
            src_idle_pct = (p < 3) ? 7 : (p < 6) ? 69 : 0;
            sink_idle_pct = (p < 3) ? 69 : (p < 6) ? 7 : 0;
            count = 0;
            while (count < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    send_request(REQ_EMIT, ADDR_W'($urandom), $urandom);
                end else if (pick < 95) begin
                    send_request(REQ_WRITE, ADDR_W'($urandom), $urandom);
                end else if (pick < 97) begin
                    send_request(REQ_RESTART, ADDR_W'($urandom), $urandom);
                end else begin
                    send_request(REQ_UNUSED, ADDR_W'($urandom), $urandom);
                end
                if (pick < 97) begin
                    count++;
                    if (count == PHASE_ITEMS / 2) begin
                        settle_block();
                    end
                end
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_register_reset();
        test_image_fill();
        test_directed_column();
        test_random_traffic();
        settle_block();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
